// File: hdl/dual_serial_channel_controller_assert.svh
// Assertion helpers for the dual serial channel controller.
`ifndef DUAL_SERIAL_CHANNEL_CONTROLLER_ASSERT_SVH
`define DUAL_SERIAL_CHANNEL_CONTROLLER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define DSCC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DSCC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dscc_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 3;

  typedef enum logic [2:0] {
    MODE_READ, MODE_WRITE, MODE_TICK, MODE_DCD, MODE_ACK, MODE_RETI, MODE_RESET, MODE_NOP
  } mode_e;

  // interrupt source bits
  localparam logic [2:0] SRC_TX  = 3'b001;
  localparam logic [2:0] SRC_RX  = 3'b010;
  localparam logic [2:0] SRC_ERR = 3'b100;
  localparam logic [2:0] SRC_ALL = 3'b111;

  localparam logic [1:0] LIVE_NONE = 2'd0;
  localparam logic [1:0] LIVE_A    = 2'd1;
  localparam logic [1:0] LIVE_B    = 2'd2;

  // WR0 command field codes
  localparam logic [2:0] CMD_RST_STATUS = 3'd2;
  localparam logic [2:0] CMD_CHAN_RESET = 3'd3;
  localparam logic [2:0] CMD_RST_TXINT  = 3'd5;
  localparam logic [2:0] CMD_ERR_RESET  = 3'd6;
  localparam logic [2:0] CMD_RETI_A     = 3'd7;

  localparam logic [2:0] REG_0 = 3'd0;
  localparam logic [2:0] REG_1 = 3'd1;
  localparam logic [2:0] REG_2 = 3'd2;
  localparam logic [2:0] REG_3 = 3'd3;

  localparam logic [7:0] RR0_RST       = 8'h2C;
  localparam logic [7:0] RR1_RST       = 8'h01;
  localparam logic [7:0] VEC_KEEP      = 8'hF1;
  localparam logic [7:0] RX_INT_MODE   = 8'h18;
  localparam logic [7:0] RR1_OVERRUN   = 8'h20;
  localparam logic [7:0] RR1_CLR_ERR   = 8'hCF;
  localparam logic [7:0] RR1_CLR_ERR6  = 8'h8F;
  localparam logic [7:0] RR_CLR_TOP    = 8'h3F;
  localparam logic [7:0] RD_NONE       = 8'hFF;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] port;
    logic [7:0] write_data;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_ready;
    logic       dcd_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       ack_valid;
    logic [7:0] ack_vector;
    logic       irq_line;
  } res_t;

  // Register and interrupt state of both channels.
  typedef struct packed {
    logic [1:0][7:0][7:0] wr;
    logic [1:0][2:0][7:0] rr;
    logic [1:0][2:0]      src;
    logic [1:0]           irq;
    logic [1:0]           live;
  } st_t;

  function automatic st_t src_clear(st_t s, logic ch, logic [2:0] m);
    st_t t;
    t = s;
    t.src[ch] = t.src[ch] & ~m;
    if ((t.src[0] | t.src[1]) == 3'b000) begin
      t.rr[0][1][1] = 1'b0;
      t.irq[ch] = 1'b0;
      if (t.live == ({1'b0, ch} + 2'd1)) t.live = LIVE_NONE;
    end
    return t;
  endfunction

  function automatic st_t src_raise(st_t s, logic ch, logic [2:0] m, logic recalc);
    st_t t;
    logic [2:0] fresh;
    t = s;
    fresh = m & ~t.src[ch];
    t.src[ch] = t.src[ch] | m;
    if (((fresh != 3'b000) || recalc) && (t.src[ch] != 3'b000) && !t.irq[ch]) begin
      t.irq[ch] = 1'b1;
      t.rr[0][1][1] = 1'b1;
    end
    return t;
  endfunction

  function automatic st_t chan_reset(st_t s, logic ch);
    st_t t;
    t = s;
    t.rr[ch][0] = RR0_RST;
    t.rr[ch][1] = RR1_RST;
    t.rr[ch][2] = 8'h00;
    return src_clear(t, ch, SRC_ALL);
  endfunction

endpackage
`default_nettype wire

// File: hdl/dscc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dscc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] port;
  logic [7:0] write_data;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_ready;
  logic       dcd_level;

  modport source (output valid, mode, port, write_data, rx_valid, rx_byte, tx_ready,
                  dcd_level, input ready);
  modport sink (input valid, mode, port, write_data, rx_valid, rx_byte, tx_ready,
                dcd_level, output ready);
endinterface
`default_nettype wire

// File: hdl/dscc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dscc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       ack_valid;
  logic [7:0] ack_vector;
  logic       irq_line;

  modport source (output valid, read_data, tx_valid, tx_byte, ack_valid, ack_vector,
                  irq_line, input ready);
  modport sink (input valid, read_data, tx_valid, tx_byte, ack_valid, ack_vector,
                irq_line, output ready);
endinterface
`default_nettype wire

// File: hdl/dscc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module dscc_core #(
  parameter int unsigned FIFO_DEPTH = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  dscc_pkg::item_t     item_i,
  output dscc_pkg::res_t      res_o
);
  import dscc_pkg::*;

  localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);

  st_t        st_q, st_d;
  logic [7:0] fifo_q [2][FIFO_DEPTH];
  logic [7:0] fifo_d [2][FIFO_DEPTH];
  logic [FW-1:0] fill_q [2];
  logic [FW-1:0] fill_d [2];

  function automatic st_t st_reset();
    st_t t;
    t = '0;
    t.rr[0][0] = RR0_RST;
    t.rr[1][0] = RR0_RST;
    t.rr[0][1] = RR1_RST;
    t.rr[1][1] = RR1_RST;
    return t;
  endfunction

  always_comb begin
    st_t        s;
    res_t       r;
    logic       ch;
    logic       dch;
    logic [2:0] ra;
    logic [7:0] v;
    s = st_q;
    r = '0;
    ch = item_i.port[1];
    dch = 1'b0;
    ra = 3'd0;
    v = 8'h00;
    fifo_d = fifo_q;
    fill_d = fill_q;
    unique case (mode_e'(item_i.mode))
      MODE_READ: begin
        if (item_i.port[0]) begin
          ra = s.wr[ch][0][2:0];
          s.wr[ch][0][2:0] = 3'b000;
          s.rr[ch][0][1] = 1'b0;
          if (!ch && ((s.src[0] | s.src[1]) != 3'b000)) s.rr[0][0][1] = 1'b1;
          if (ra == REG_0 || ra == REG_1) r.read_data = s.rr[ch][ra[1:0]];
          else if (ra == REG_2 && ch) r.read_data = s.rr[1][2];
          else r.read_data = RD_NONE;
        end else begin
          r.read_data = fifo_q[ch][0];
          for (int i = 0; i + 1 < FIFO_DEPTH; i++) fifo_d[ch][i] = fifo_q[ch][i + 1];
          if (fill_q[ch] != '0) fill_d[ch] = fill_q[ch] - FW'(1);
          if (fill_d[ch] == '0) s.rr[ch][0][0] = 1'b0;
          s = src_clear(s, ch, SRC_RX);
          s.rr[ch][0] = s.rr[ch][0] & RR_CLR_TOP;
          s.rr[ch][1] = s.rr[ch][1] & RR_CLR_TOP;
          if ((fill_d[ch] != '0) && s.wr[ch][1][4]) s = src_raise(s, ch, SRC_RX, 1'b0);
        end
      end
      MODE_WRITE: begin
        if (item_i.port[0]) begin
          ra = s.wr[ch][0][2:0];
          if (ra != REG_0) begin
            s.wr[ch][ra] = item_i.write_data;
            if (ch && ra == REG_2) s.rr[1][2] = item_i.write_data;
            s.wr[ch][0][2:0] = 3'b000;
          end else begin
            s.wr[ch][0] = item_i.write_data;
            unique case (item_i.write_data[5:3])
              CMD_RST_STATUS: begin
                s = src_clear(s, ch, SRC_ERR);
                s.rr[ch][1] = s.rr[ch][1] & RR1_CLR_ERR;
              end
              CMD_CHAN_RESET: s = chan_reset(s, ch);
              CMD_RST_TXINT:  s = src_clear(s, ch, SRC_TX);
              CMD_ERR_RESET:  s.rr[ch][1] = s.rr[ch][1] & RR1_CLR_ERR6;
              CMD_RETI_A: begin
                if (!ch) begin
                  s.irq[0] = 1'b0;
                  s.rr[0][1][1] = 1'b0;
                  s = src_clear(s, 1'b0, SRC_ALL);
                  s = src_clear(s, 1'b1, SRC_ALL);
                end
              end
              default: ;
            endcase
          end
        end else begin
          s.rr[ch][0][2] = 1'b0;
          s = src_clear(s, ch, SRC_TX);
          r.tx_valid = 1'b1;
          r.tx_byte = item_i.write_data;
        end
      end
      MODE_TICK: begin
        if (item_i.rx_valid && s.wr[ch][3][0]) begin
          if (fill_q[ch] >= FW'(FIFO_DEPTH)) begin
            fifo_d[ch][FIFO_DEPTH-1] = item_i.rx_byte;
            s.rr[ch][1] = s.rr[ch][1] | RR1_OVERRUN;
            s = src_raise(s, ch, SRC_ERR, 1'b0);
          end else begin
            for (int i = 0; i < FIFO_DEPTH; i++) begin
              if (fill_q[ch] == FW'(i)) fifo_d[ch][i] = item_i.rx_byte;
            end
            fill_d[ch] = fill_q[ch] + FW'(1);
            s.rr[ch][0][0] = 1'b1;
            // rx interrupt mode: off, first byte only, or every byte
            if ((s.wr[ch][1] & RX_INT_MODE) == 8'h08) begin
              if (fill_d[ch] == FW'(1)) s = src_raise(s, ch, SRC_RX, 1'b0);
            end else if ((s.wr[ch][1] & RX_INT_MODE) != 8'h00) begin
              s = src_raise(s, ch, SRC_RX, 1'b0);
            end
          end
        end
        if (item_i.tx_ready && !s.rr[ch][0][2]) begin
          s.rr[ch][0][2] = 1'b1;
          if (s.wr[ch][1][1]) s = src_raise(s, ch, SRC_TX, 1'b0);
        end
      end
      MODE_DCD: begin
        s.rr[ch][0][3] = ~item_i.dcd_level;
        if (s.wr[ch][1][0]) s = src_raise(s, ch, SRC_ERR, 1'b0);
      end
      MODE_ACK: begin
        s = src_raise(s, 1'b0, 3'b000, 1'b1);
        s = src_raise(s, 1'b1, 3'b000, 1'b1);
        if (s.live == LIVE_NONE && (s.irq[0] || s.irq[1])) begin
          dch = !s.irq[0];
          v = s.wr[1][2];
          if (s.wr[1][1][2]) begin
            v = v & VEC_KEEP;
            if (!dch) v[3] = 1'b1;
            if (s.src[dch][1]) v[2] = 1'b1;
            if (s.src[dch][2]) v[1] = 1'b1;
          end
          s = src_clear(s, dch, SRC_TX);
          s.live = {1'b0, dch} + 2'd1;
          r.ack_valid = 1'b1;
          r.ack_vector = v;
        end
      end
      MODE_RETI: begin
        if (s.live == LIVE_A) s.irq[0] = 1'b0;
        if (s.live == LIVE_B) s.irq[1] = 1'b0;
        s.live = LIVE_NONE;
      end
      MODE_RESET: begin
        s = chan_reset(s, 1'b0);
        s = chan_reset(s, 1'b1);
        s.live = LIVE_NONE;
      end
      MODE_NOP: ;
    endcase
    r.irq_line = s.irq[0] | s.irq[1];
    st_d = s;
    res_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= st_reset();
      fill_q[0] <= '0;
      fill_q[1] <= '0;
    end else if (take_i) begin
      st_q <= st_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) fifo_q <= fifo_d;
  end

`include "dual_serial_channel_controller_assert.svh"

  `DSCC_ASSERT(a_live_code, clk_i, rst_ni, st_q.live != 2'd3, "live channel code invalid")
  `DSCC_ASSERT(a_fill_a, clk_i, rst_ni, fill_q[0] <= FW'(FIFO_DEPTH), "rx fill beyond depth")
  `DSCC_ASSERT(a_fill_b, clk_i, rst_ni, fill_q[1] <= FW'(FIFO_DEPTH), "rx fill beyond depth")
  `DSCC_ASSERT_NEXT(a_ack_live, clk_i, rst_ni, take_i && res_o.ack_valid, st_q.live != LIVE_NONE, "ack did not mark a channel in service")

endmodule
`default_nettype wire

// File: hdl/dual_serial_channel_controller.sv
// Two-channel async serial controller, register-pointer access. Every item (bus read or
// write, channel tick, DCD change, interrupt acknowledge, return from interrupt, reset)
// gives exactly one result. An item is processed in the cycle it is accepted and its
// result sits in the output register from the next cycle; one item per cycle is taken
// for as long as the output side keeps taking results, and the input stays ready while
// the held result is being taken in the same cycle. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module dual_serial_channel_controller #(
  parameter int unsigned FIFO_DEPTH = dscc_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dscc_in_if.sink    in_i,
  dscc_out_if.source out_o
);
  import dscc_pkg::*;

  logic  take;
  item_t item;
  res_t  res, res_q;
  logic  out_valid_q, out_valid_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take = in_i.valid && in_i.ready;

  assign item = '{mode: in_i.mode, port: in_i.port, write_data: in_i.write_data,
                  rx_valid: in_i.rx_valid, rx_byte: in_i.rx_byte,
                  tx_ready: in_i.tx_ready, dcd_level: in_i.dcd_level};

  dscc_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (item),
    .res_o  (res)
  );

  assign out_valid_d = take || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = res_q.read_data;
  assign out_o.tx_valid   = res_q.tx_valid;
  assign out_o.tx_byte    = res_q.tx_byte;
  assign out_o.ack_valid  = res_q.ack_valid;
  assign out_o.ack_vector = res_q.ack_vector;
  assign out_o.irq_line   = res_q.irq_line;

endmodule
`default_nettype wire

// File: tb/sv/dscc_checker.sv
`timescale 1ns / 1ps
module dscc_checker
  import dscc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dscc_in_if   in_m,
  dscc_out_if  out_m,
  output int   errors_o,
  output int   pending_o
);

  localparam int DEPTH = FIFO_DEPTH_DEF;

  // predicted controller state
  logic [7:0] wreg [2][8];
  logic [7:0] rreg [2][3];
  logic [7:0] rx_q [2][DEPTH];
  int         rx_cnt [2];
  logic [2:0] cause [2];
  logic       irq_up [2];
  logic [1:0] serving;

  res_t expected_results[$];

  function automatic void drop_cause(int ch, logic [2:0] m);
    cause[ch] = cause[ch] & ~m;
    if ((cause[0] | cause[1]) == 3'b000) begin
      rreg[0][1][1] = 1'b0;
      irq_up[ch] = 1'b0;
      if (serving == 2'(ch + 1)) serving = LIVE_NONE;
    end
  endfunction

  function automatic void post_cause(int ch, logic [2:0] m, logic reeval);
    logic [2:0] added;
    added = m & ~cause[ch];
    cause[ch] = cause[ch] | m;
    if ((added != 3'b000 || reeval) && cause[ch] != 3'b000 && !irq_up[ch]) begin
      irq_up[ch] = 1'b1;
      rreg[0][1][1] = 1'b1;
    end
  endfunction

  function automatic void restart_channel(int ch);
    rreg[ch][0] = RR0_RST;
    rreg[ch][1] = RR1_RST;
    rreg[ch][2] = 8'h00;
    drop_cause(ch, SRC_ALL);
  endfunction

  function automatic void push_rx_byte(int ch, logic [7:0] b);
    logic [1:0] rx_mode;
    if (!wreg[ch][3][0]) return;
    if (rx_cnt[ch] >= DEPTH) begin
      // overrun: newest byte lands in the last slot
      rx_q[ch][DEPTH-1] = b;
      rreg[ch][1] = rreg[ch][1] | RR1_OVERRUN;
      post_cause(ch, SRC_ERR, 1'b0);
      return;
    end
    rx_q[ch][rx_cnt[ch]] = b;
    rx_cnt[ch]++;
    rreg[ch][0][0] = 1'b1;
    rx_mode = wreg[ch][1][4:3];
    if (rx_mode == 2'b01) begin
      if (rx_cnt[ch] == 1) post_cause(ch, SRC_RX, 1'b0);
    end else if (rx_mode[1]) begin
      post_cause(ch, SRC_RX, 1'b0);
    end
  endfunction

  function automatic logic [7:0] host_read(int ch, logic ctrl);
    logic [2:0] r;
    logic [7:0] b;
    if (ctrl) begin
      r = wreg[ch][0][2:0];
      wreg[ch][0][2:0] = REG_0;
      rreg[ch][0][1] = 1'b0;
      if (ch == 0 && (cause[0] | cause[1]) != 3'b000) rreg[0][0][1] = 1'b1;
      if (r == REG_0 || r == REG_1) return rreg[ch][r];
      if (r == REG_2 && ch == 1) return rreg[1][2];
      return RD_NONE;
    end
    b = rx_q[ch][0];
    for (int i = 0; i + 1 < DEPTH; i++) rx_q[ch][i] = rx_q[ch][i+1];
    if (rx_cnt[ch] > 0) rx_cnt[ch]--;
    if (rx_cnt[ch] == 0) rreg[ch][0][0] = 1'b0;
    drop_cause(ch, SRC_RX);
    rreg[ch][0] = rreg[ch][0] & RR_CLR_TOP;
    rreg[ch][1] = rreg[ch][1] & RR_CLR_TOP;
    if (rx_cnt[ch] > 0 && wreg[ch][1][4]) post_cause(ch, SRC_RX, 1'b0);
    return b;
  endfunction

  function automatic void host_ctrl_write(int ch, logic [7:0] val);
    logic [2:0] r;
    r = wreg[ch][0][2:0];
    if (r != REG_0) begin
      wreg[ch][r] = val;
      if (ch == 1 && r == REG_2) rreg[1][2] = val;
      wreg[ch][0][2:0] = REG_0;
      return;
    end
    wreg[ch][0] = val;
    case (val[5:3])
      CMD_RST_STATUS: begin
        drop_cause(ch, SRC_ERR);
        rreg[ch][1] = rreg[ch][1] & RR1_CLR_ERR;
      end
      CMD_CHAN_RESET: restart_channel(ch);
      CMD_RST_TXINT:  drop_cause(ch, SRC_TX);
      CMD_ERR_RESET:  rreg[ch][1] = rreg[ch][1] & RR1_CLR_ERR6;
      CMD_RETI_A: begin
        if (ch == 0) begin
          irq_up[0] = 1'b0;
          rreg[0][1][1] = 1'b0;
          drop_cause(0, SRC_ALL);
          drop_cause(1, SRC_ALL);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic grant_vector(int ch, output logic [7:0] vec);
    logic [7:0] v;
    v = wreg[1][2];
    vec = 8'h00;
    if (serving != LIVE_NONE || !irq_up[ch]) return 1'b0;
    if (wreg[1][1][2]) begin
      // status affects vector: bits 3..1 carry channel and cause
      v = v & VEC_KEEP;
      if (ch == 0) v[3] = 1'b1;
      if (cause[ch][1]) v[2] = 1'b1;
      if (cause[ch][2]) v[1] = 1'b1;
    end
    drop_cause(ch, SRC_TX);
    serving = 2'(ch + 1);
    vec = v;
    return 1'b1;
  endfunction

  function automatic res_t apply_item(item_t it);
    res_t o;
    int ch;
    logic [7:0] v;
    o = '0;
    ch = it.port[1];
    case (mode_e'(it.mode))
      MODE_READ: o.read_data = host_read(ch, it.port[0]);
      MODE_WRITE: begin
        if (it.port[0]) host_ctrl_write(ch, it.write_data);
        else begin
          rreg[ch][0][2] = 1'b0;
          drop_cause(ch, SRC_TX);
          o.tx_valid = 1'b1;
          o.tx_byte  = it.write_data;
        end
      end
      MODE_TICK: begin
        if (it.rx_valid) push_rx_byte(ch, it.rx_byte);
        if (it.tx_ready && !rreg[ch][0][2]) begin
          rreg[ch][0][2] = 1'b1;
          if (wreg[ch][1][1]) post_cause(ch, SRC_TX, 1'b0);
        end
      end
      MODE_DCD: begin
        rreg[ch][0][3] = !it.dcd_level;
        if (wreg[ch][1][0]) post_cause(ch, SRC_ERR, 1'b0);
      end
      MODE_ACK: begin
        post_cause(0, 3'b000, 1'b1);
        post_cause(1, 3'b000, 1'b1);
        if (grant_vector(0, v) || grant_vector(1, v)) begin
          o.ack_valid  = 1'b1;
          o.ack_vector = v;
        end
      end
      MODE_RETI: begin
        if (serving == LIVE_A) irq_up[0] = 1'b0;
        if (serving == LIVE_B) irq_up[1] = 1'b0;
        serving = LIVE_NONE;
      end
      MODE_RESET: begin
        restart_channel(0);
        restart_channel(1);
        serving = LIVE_NONE;
      end
      default: ;
    endcase
    o.irq_line = irq_up[0] | irq_up[1];
    return o;
  endfunction

  function automatic int check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    res_t  e;
    int    bad;
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 8; r++) wreg[c][r] = 8'h00;
        for (int i = 0; i < DEPTH; i++) rx_q[c][i] = 8'h00;
        rx_cnt[c] = 0;
        cause[c]  = 3'b000;
        irq_up[c] = 1'b0;
      end
      serving = LIVE_NONE;
      restart_channel(0);
      restart_channel(1);
      expected_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // result side first so an item accepted this edge is not matched early
      if (out_m.valid && out_m.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          errors_o++;
        end else begin
          e = expected_results.pop_front();
          bad = check_field("read_data", e.read_data, out_m.read_data)
              + check_field("tx_valid", e.tx_valid, out_m.tx_valid)
              + check_field("tx_byte", e.tx_byte, out_m.tx_byte)
              + check_field("ack_valid", e.ack_valid, out_m.ack_valid)
              + check_field("ack_vector", e.ack_vector, out_m.ack_vector)
              + check_field("irq_line", e.irq_line, out_m.irq_line);
          if (bad != 0) errors_o++;
        end
      end
      if (in_m.valid && in_m.ready) begin
        it.mode       = in_m.mode;
        it.port       = in_m.port;
        it.write_data = in_m.write_data;
        it.rx_valid   = in_m.rx_valid;
        it.rx_byte    = in_m.rx_byte;
        it.tx_ready   = in_m.tx_ready;
        it.dcd_level  = in_m.dcd_level;
        expected_results.push_back(apply_item(it));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: tb/sv/tb_dual_serial_channel_controller.sv
`timescale 1ns / 1ps
module tb_dual_serial_channel_controller;
  import dscc_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 800;
  localparam int STALL_AT     = 1100;
  localparam int STALL_LEN    = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cyc = 0;
  int   errors;
  int   pending;
  bit   stim_done = 1'b0;

  dscc_in_if  in_if();
  dscc_out_if out_if();

  dual_serial_channel_controller dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  dscc_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_m     (in_if),
    .out_m    (out_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit quiet_window();
    return cyc >= QUIET_FROM && cyc < QUIET_TO;
  endfunction

  // result side: random back-pressure, none in the quiet window, plus one long hold-off
  initial begin
    int hold;
    bit stalled;
    hold = 0;
    stalled = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!stalled && cyc >= STALL_AT) begin
        stalled = 1'b1;
        hold = STALL_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (quiet_window()) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  task automatic put(logic [2:0] mode, logic [1:0] port, logic [7:0] wd = 8'h00,
                     logic rv = 1'b0, logic [7:0] rb = 8'h00, logic tr = 1'b0,
                     logic dl = 1'b0);
    while (!quiet_window() && $urandom_range(0, 99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.port       <= port;
    in_if.write_data <= wd;
    in_if.rx_valid   <= rv;
    in_if.rx_byte    <= rb;
    in_if.tx_ready   <= tr;
    in_if.dcd_level  <= dl;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // pointer transfer into WR0, then the value transfer
  task automatic set_reg(bit ch, logic [2:0] r, logic [7:0] val);
    put(MODE_WRITE, {ch, 1'b1}, {5'b00000, r});
    put(MODE_WRITE, {ch, 1'b1}, val);
  endtask

  initial begin
    int sel;
    bit ch;
    in_if.valid      <= 1'b0;
    in_if.mode       <= MODE_NOP;
    in_if.port       <= 2'b00;
    in_if.write_data <= 8'h00;
    in_if.rx_valid   <= 1'b0;
    in_if.rx_byte    <= 8'h00;
    in_if.tx_ready   <= 1'b0;
    in_if.dcd_level  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: enable rx on both channels, interrupts and vector on channel B, then fill
    // both FIFOs so every slot holds a written byte before any data read
    put(MODE_READ, 2'b01);
    set_reg(0, REG_3, 8'h01);
    set_reg(1, REG_3, 8'h01);
    set_reg(1, REG_2, 8'hFF);
    set_reg(1, REG_1, 8'h17);
    put(MODE_TICK, 2'b00, 8'h00, 1'b1, 8'h00, 1'b1);
    put(MODE_TICK, 2'b00, 8'h00, 1'b1, 8'hFF);
    put(MODE_TICK, 2'b00, 8'h00, 1'b1, 8'hA5);
    put(MODE_TICK, 2'b00, 8'h00, 1'b1, 8'h5A);   // overrun
    put(MODE_TICK, 2'b10, 8'h00, 1'b1, 8'h3C, 1'b1);
    put(MODE_TICK, 2'b10, 8'h00, 1'b1, 8'hC3);
    put(MODE_TICK, 2'b10, 8'h00, 1'b1, 8'h81);
    put(MODE_ACK, 2'b00);
    put(MODE_ACK, 2'b00);                          // channel in service
    put(MODE_RETI, 2'b00);
    put(MODE_READ, 2'b00);
    put(MODE_DCD, 2'b10, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
    put(MODE_WRITE, 2'b00, 8'hFF);
    put(MODE_NOP, 2'b11);
    put(MODE_RESET, 2'b00);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      ch = $urandom_range(0, 1);
      if (sel < 28) begin
        set_reg(ch, 3'($urandom_range(1, 7)), 8'($urandom));
        n++;
      end else if (sel < 36) put(MODE_WRITE, {ch, 1'b1}, 8'($urandom));
      else if (sel < 52)
        put(MODE_TICK, 2'($urandom), 8'($urandom), $urandom_range(0, 9) < 7,
            8'($urandom), 1'($urandom));
      else if (sel < 65) put(MODE_READ, {ch, 1'b0}, 8'($urandom));
      else if (sel < 73) put(MODE_READ, {ch, 1'b1}, 8'($urandom));
      else if (sel < 80) put(MODE_WRITE, {ch, 1'b0}, 8'($urandom));
      else if (sel < 86)
        put(MODE_DCD, 2'($urandom), 8'($urandom), 1'b0, 8'h00, 1'b0, 1'($urandom));
      else if (sel < 93) put(MODE_ACK, 2'($urandom));
      else if (sel < 97) put(MODE_RETI, 2'($urandom));
      else if (sel < 99) put(MODE_RESET, 2'($urandom));
      else put(MODE_NOP, 2'($urandom), 8'($urandom));
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
